### rtl/egcd_pkg.sv
// Package for the extended gcd trace block: widths, microcode encoding
// and the control program.
// No dependencies.
package egcd_pkg;

  localparam int WIDTH      = 32;  // operand width
  localparam int COEF_W     = 34;  // coefficient width, two's complement
  localparam int MAX_ROUNDS = 46;
  localparam int ROUND_W    = $clog2(MAX_ROUNDS + 1);
  localparam int BIT_W      = $clog2(WIDTH);
  localparam int PC_W       = 3;

  typedef enum logic [2:0] {
    OP_LOAD  = 3'd0,  // take a transaction when start is high
    OP_NOP   = 3'd1,
    OP_SETUP = 3'd2,  // pick dividend and divisor
    OP_DIV   = 3'd3,  // one quotient bit plus coefficient products
    OP_STEP  = 3'd4,  // write back remainder and coefficients, emit record
    OP_FINAL = 3'd5   // emit gcd record
  } dp_op_t;

  typedef enum logic [2:0] {
    C_NEVER   = 3'd0,
    C_ALWAYS  = 3'd1,
    C_NOSTART = 3'd2,
    C_DONE    = 3'd3,
    C_MORE    = 3'd4
  } jcond_t;

  typedef struct packed {
    dp_op_t          op;
    jcond_t          cond;
    logic [PC_W-1:0] target;
  } uword_t;

  localparam logic [PC_W-1:0] PC_IDLE  = 3'd0;
  localparam logic [PC_W-1:0] PC_TEST  = 3'd1;
  localparam logic [PC_W-1:0] PC_SETUP = 3'd2;
  localparam logic [PC_W-1:0] PC_DIV   = 3'd3;
  localparam logic [PC_W-1:0] PC_STEP  = 3'd4;
  localparam logic [PC_W-1:0] PC_FINAL = 3'd5;

  // Control store
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      PC_IDLE:  w = '{op: OP_LOAD,  cond: C_NOSTART, target: PC_IDLE};
      PC_TEST:  w = '{op: OP_NOP,   cond: C_DONE,    target: PC_FINAL};
      PC_SETUP: w = '{op: OP_SETUP, cond: C_NEVER,   target: PC_IDLE};
      PC_DIV:   w = '{op: OP_DIV,   cond: C_MORE,    target: PC_DIV};
      PC_STEP:  w = '{op: OP_STEP,  cond: C_ALWAYS,  target: PC_TEST};
      PC_FINAL: w = '{op: OP_FINAL, cond: C_ALWAYS,  target: PC_IDLE};
      default:  w = '{op: OP_NOP,   cond: C_ALWAYS,  target: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

### rtl/extended_gcd_trace_top.sv
// Extended gcd trace: microcoded sequencer driving a bit-serial divider
// and shift-add coefficient update. Depends on egcd_pkg.
//
// Usage:
//   Drive in_first_operand / in_second_operand and raise start; the
//   transaction is taken at a clock edge where start is high and busy low.
//   The block then runs the extended Euclidean algorithm and emits one
//   record per division round (out_record_kind 0: quotient and the new x,y
//   coefficients) and a closing record (out_record_kind 1, out_last 1)
//   carrying the gcd. Each record is present for one cycle with out_strobe
//   high; the receiver cannot stall, so it must take every record.
// Timing:
//   Each round runs test, setup, 32 restoring divide steps and
//   write-back; the divider yields one quotient bit per cycle. A run
//   has at most 46 rounds, and busy stays high from the accepting edge
//   until the closing record is shown. A new transaction can be taken in
//   the cycle the closing record is shown.
// Reset:
//   rst_n low (synchronous) returns the sequencer to idle and drops
//   out_strobe; any run in progress is discarded.
module extended_gcd_trace_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [31:0]                       in_first_operand,
  input  logic [31:0]                       in_second_operand,
  output logic                              out_strobe,
  output logic                              out_record_kind,
  output logic [31:0]                       out_quotient,
  output logic signed [33:0]                out_coef_x,
  output logic signed [33:0]                out_coef_y,
  output logic [31:0]                       out_gcd_value,
  output logic                              out_last
);

  localparam int W  = egcd_pkg::WIDTH;
  localparam int CW = egcd_pkg::COEF_W;

  logic [egcd_pkg::PC_W-1:0]    pc_r, pc_nxt;
  egcd_pkg::uword_t             uw;

  logic [W-1:0]                 a_r, a_nxt, b_r, b_nxt;
  logic [W-1:0]                 dvd_r, dvd_nxt, dvs_r, dvs_nxt, rem_r, rem_nxt;
  logic [CW-1:0]                x1_r, x1_nxt, x2_r, x2_nxt;
  logic [CW-1:0]                y1_r, y1_nxt, y2_r, y2_nxt;
  logic [CW-1:0]                px_r, px_nxt, py_r, py_nxt;
  logic [egcd_pkg::ROUND_W-1:0] n_r, n_nxt;
  logic [egcd_pkg::BIT_W-1:0]   cnt_r, cnt_nxt;
  logic                         sel_r, sel_nxt;  // a is the dividend

  logic                         strobe_r, strobe_nxt;
  logic                         kind_r, kind_nxt;
  logic [W-1:0]                 quo_r, quo_nxt, gcd_r, gcd_nxt;
  logic [CW-1:0]                cx_r, cx_nxt, cy_r, cy_nxt;

  logic                         done, jump;
  logic [W:0]                   trial;
  logic                         qbit;
  logic [CW-1:0]                x_new, y_new;

  assign uw    = egcd_pkg::ucode(pc_r);
  assign busy  = (pc_r != egcd_pkg::PC_IDLE);

  assign done  = (a_r == b_r) || (a_r == '0) || (b_r == '0) ||
                 (n_r == egcd_pkg::ROUND_W'(egcd_pkg::MAX_ROUNDS));

  // restoring divide: shift in next dividend bit, try the subtraction
  assign trial = {rem_r, dvd_r[W-1]} - {1'b0, dvs_r};
  assign qbit  = ~trial[W];

  assign x_new = x2_r - px_r;
  assign y_new = y2_r - py_r;

  always_comb begin
    case (uw.cond)
      egcd_pkg::C_NEVER:   jump = 1'b0;
      egcd_pkg::C_ALWAYS:  jump = 1'b1;
      egcd_pkg::C_NOSTART: jump = ~start;
      egcd_pkg::C_DONE:    jump = done;
      egcd_pkg::C_MORE:    jump = (cnt_r != '0);
      default:             jump = 1'b1;
    endcase
    pc_nxt = jump ? uw.target : pc_r + 1'b1;
  end

  always_comb begin
    a_nxt      = a_r;
    b_nxt      = b_r;
    dvd_nxt    = dvd_r;
    dvs_nxt    = dvs_r;
    rem_nxt    = rem_r;
    x1_nxt     = x1_r;
    x2_nxt     = x2_r;
    y1_nxt     = y1_r;
    y2_nxt     = y2_r;
    px_nxt     = px_r;
    py_nxt     = py_r;
    n_nxt      = n_r;
    cnt_nxt    = cnt_r;
    sel_nxt    = sel_r;
    strobe_nxt = 1'b0;
    kind_nxt   = kind_r;
    quo_nxt    = quo_r;
    gcd_nxt    = gcd_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    case (uw.op)
      egcd_pkg::OP_LOAD: begin
        if (start) begin
          a_nxt  = in_first_operand;
          b_nxt  = in_second_operand;
          x2_nxt = CW'(1);
          y2_nxt = '0;
          x1_nxt = '0;
          y1_nxt = CW'(1);
          n_nxt  = '0;
        end
      end
      egcd_pkg::OP_SETUP: begin
        sel_nxt = (a_r > b_r);
        dvd_nxt = (a_r > b_r) ? a_r : b_r;
        dvs_nxt = (a_r > b_r) ? b_r : a_r;
        rem_nxt = '0;
        px_nxt  = '0;
        py_nxt  = '0;
        cnt_nxt = egcd_pkg::BIT_W'(W - 1);
      end
      egcd_pkg::OP_DIV: begin
        // quotient bits fill dvd from the bottom; products build MSB first
        rem_nxt = qbit ? trial[W-1:0] : {rem_r[W-2:0], dvd_r[W-1]};
        dvd_nxt = {dvd_r[W-2:0], qbit};
        px_nxt  = {px_r[CW-2:0], 1'b0} + (qbit ? x1_r : '0);
        py_nxt  = {py_r[CW-2:0], 1'b0} + (qbit ? y1_r : '0);
        cnt_nxt = cnt_r - 1'b1;
      end
      egcd_pkg::OP_STEP: begin
        if (sel_r) begin
          a_nxt = rem_r;
        end else begin
          b_nxt = rem_r;
        end
        x1_nxt     = x_new;
        x2_nxt     = x1_r;
        y1_nxt     = y_new;
        y2_nxt     = y1_r;
        n_nxt      = n_r + 1'b1;
        strobe_nxt = 1'b1;
        kind_nxt   = 1'b0;
        quo_nxt    = dvd_r;
        cx_nxt     = x_new;
        cy_nxt     = y_new;
        gcd_nxt    = '0;
      end
      egcd_pkg::OP_FINAL: begin
        strobe_nxt = 1'b1;
        kind_nxt   = 1'b1;
        quo_nxt    = '0;
        cx_nxt     = '0;
        cy_nxt     = '0;
        gcd_nxt    = (a_r != '0) ? a_r : b_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r     <= egcd_pkg::PC_IDLE;
      strobe_r <= 1'b0;
    end else begin
      pc_r     <= pc_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    dvd_r  <= dvd_nxt;
    dvs_r  <= dvs_nxt;
    rem_r  <= rem_nxt;
    x1_r   <= x1_nxt;
    x2_r   <= x2_nxt;
    y1_r   <= y1_nxt;
    y2_r   <= y2_nxt;
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    n_r    <= n_nxt;
    cnt_r  <= cnt_nxt;
    sel_r  <= sel_nxt;
    kind_r <= kind_nxt;
    quo_r  <= quo_nxt;
    gcd_r  <= gcd_nxt;
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
  end

  assign out_strobe      = strobe_r;
  assign out_record_kind = kind_r;
  assign out_quotient    = quo_r;
  assign out_coef_x      = cx_r;
  assign out_coef_y      = cy_r;
  assign out_gcd_value   = gcd_r;
  assign out_last        = kind_r;

endmodule
